// ===== src/apt_pkg.sv =====
package apt_pkg;

  // Fixed point format of every coordinate and coefficient.
  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;
  // Point operand after the translation has been taken off (inverse mode).
  localparam int OPW       = CW + 2;
  // Coefficient times operand.
  localparam int PW        = CW + OPW;
  // Sum or difference of two products plus translation.
  localparam int NV        = PW + 1;
  // Determinant a*d - b*c.
  localparam int DETW      = 2 * CW + 1;
  // Divider numerator: magnitude of a sum with the fraction bits appended.
  localparam int NW        = NV + FRAC_BITS;
  localparam int DREMW     = DETW + 1;
  localparam int CNTW      = $clog2(NW);
  // Request queue between front and back.
  localparam int QDEPTH    = 4;
  localparam int QPTRW     = $clog2(QDEPTH);
  localparam int CFG_IDX_W = 3;

  localparam logic signed [CW-1:0] COEF_ONE = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A  = 3'd0,
    REG_COEF_B  = 3'd1,
    REG_COEF_C  = 3'd2,
    REG_COEF_D  = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    REQ_FORWARD = 1'b0,
    REQ_INVERSE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] d;
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
  } cfg_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    req_type_e             kind;
    logic signed [OPW-1:0] op_x;
    logic signed [OPW-1:0] op_y;
  } entry_t;

  typedef struct packed {
    logic [CW-1:0] val;
    logic          sat;
  } clamp_t;

  // Applies a sign to a magnitude and clamps it to the signed 32-bit range.
  function automatic clamp_t clamp32(input logic [NW-1:0] mag, input logic neg);
    clamp_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > NW'(SAT_MIN)) begin
        r.val = SAT_MIN;
        r.sat = 1'b1;
      end else begin
        r.val = -mag[CW-1:0];
      end
    end else begin
      if (mag > NW'(SAT_MAX)) begin
        r.val = SAT_MAX;
        r.sat = 1'b1;
      end else begin
        r.val = mag[CW-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== src/apt_front.sv =====
module apt_front (
  input  logic                    req_type_i,
  input  logic signed [31:0]      x_in_i,
  input  logic signed [31:0]      y_in_i,
  input  logic signed [31:0]      origin_x_i,
  input  logic signed [31:0]      origin_y_i,
  input  apt_pkg::cfg_t           cfg_i,
  output apt_pkg::entry_t         entry_o
);

  logic signed [apt_pkg::OPW-1:0] tx_eff;
  logic signed [apt_pkg::OPW-1:0] ty_eff;
  logic signed [apt_pkg::OPW-1:0] u;
  logic signed [apt_pkg::OPW-1:0] v;

  // Inverse requests take the shifted translation off the point here.
  assign tx_eff = apt_pkg::OPW'(cfg_i.tx) - apt_pkg::OPW'(origin_x_i);
  assign ty_eff = apt_pkg::OPW'(cfg_i.ty) - apt_pkg::OPW'(origin_y_i);
  assign u      = apt_pkg::OPW'(x_in_i) - tx_eff;
  assign v      = apt_pkg::OPW'(y_in_i) - ty_eff;

  // Classify the request and pick the operands the back end multiplies.
  always_comb begin
    entry_o.kind = apt_pkg::req_type_e'(req_type_i);
    if (entry_o.kind == apt_pkg::REQ_INVERSE) begin
      entry_o.op_x = u;
      entry_o.op_y = v;
    end else begin
      entry_o.op_x = apt_pkg::OPW'(x_in_i);
      entry_o.op_y = apt_pkg::OPW'(y_in_i);
    end
  end

endmodule

// ===== src/apt_fifo.sv =====
module apt_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  apt_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output apt_pkg::entry_t head_o
);

  apt_pkg::entry_t              mem_q [apt_pkg::QDEPTH];
  logic [apt_pkg::QPTRW-1:0]    wr_ptr_q;
  logic [apt_pkg::QPTRW-1:0]    rd_ptr_q;
  logic [apt_pkg::QPTRW:0]      count_q;

  assign full_o  = (count_q == (apt_pkg::QPTRW+1)'(apt_pkg::QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

// ===== src/apt_div.sv =====
module apt_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [apt_pkg::NW-1:0]    num_i,
  input  logic [apt_pkg::DETW-1:0]  den_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [apt_pkg::NW-1:0]    quot_o
);

  logic                          busy_q;
  logic [apt_pkg::CNTW-1:0]      cnt_q;
  logic [apt_pkg::NW-1:0]        num_q;
  logic [apt_pkg::DETW-1:0]      den_q;
  logic [apt_pkg::DREMW-1:0]     rem_q;
  logic [apt_pkg::DREMW-1:0]     rem_sh;
  logic                          ge;

  // One restoring step per cycle; quotient bits shift into the numerator.
  assign rem_sh = {rem_q[apt_pkg::DREMW-2:0], num_q[apt_pkg::NW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == apt_pkg::CNTW'(apt_pkg::NW - 1));
  assign quot_o = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (done_o) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[apt_pkg::NW-2:0], ge};
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    end
  end

endmodule

// ===== src/apt_back.sv =====
module apt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  apt_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  input  apt_pkg::entry_t    q_entry_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] x_out_o,
  output logic signed [31:0] y_out_o,
  output logic               saturated_o,
  output logic               singular_o
);

  localparam int PW   = apt_pkg::PW;
  localparam int NV   = apt_pkg::NV;
  localparam int DETW = apt_pkg::DETW;
  localparam int NW   = apt_pkg::NW;
  localparam int CW   = apt_pkg::CW;
  localparam int F    = apt_pkg::FRAC_BITS;

  // Stage 1: products.
  logic                    s1_valid_q;
  logic                    s1_inv_q;
  logic signed [PW-1:0]    p0_q, p1_q, p2_q, p3_q;
  logic signed [2*CW-1:0]  pad_q, pbc_q;
  logic signed [PW-1:0]    p0_d, p1_d, p2_d, p3_d;
  logic signed [CW-1:0]    m0, m2, m3;
  logic signed [apt_pkg::OPW-1:0] o0, o2, o3;

  // Stage 2: sums and determinant.
  logic                    s2_valid_q;
  logic                    s2_inv_q;
  logic signed [NV-1:0]    nx_q, ny_q;
  logic [DETW-1:0]         det_abs_q;
  logic                    det_neg_q;
  logic                    det_zero_q;
  logic signed [NV-1:0]    nx_d, ny_d;
  logic signed [DETW-1:0]  det_d;

  // Output register.
  logic                    out_valid_q;
  logic [CW-1:0]           x_out_q, y_out_q;
  logic                    sat_q, sing_q;

  // Divider handshake.
  logic                    div_done_q;
  logic                    div_start;
  logic                    div_busy_x, div_busy_y;
  logic                    div_fin_x, div_fin_y;
  logic                    div_fin;
  logic [NW-1:0]           quot_x, quot_y;

  logic                    need_div, res_ok, out_free, out_load;
  logic                    s2_free, s1_adv, s1_free;
  logic [NV-1:0]           nx_abs, ny_abs;
  logic [NW-1:0]           mag_x, mag_y;
  logic                    neg_x, neg_y;
  apt_pkg::clamp_t         cx, cy;

  // Flow control from the output backwards.
  assign need_div  = s2_inv_q && !det_zero_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign res_ok    = s2_valid_q && (!need_div || div_done_q);
  assign out_load  = res_ok && out_free;
  assign s2_free   = !s2_valid_q || out_load;
  assign s1_adv    = s1_valid_q && s2_free;
  assign s1_free   = !s1_valid_q || s1_adv;
  assign q_pop_o   = q_valid_i && s1_free;

  // Operand selection: forward uses a,c,b,d on x,y; inverse d,c,a,b on u,v.
  always_comb begin
    if (q_entry_i.kind == apt_pkg::REQ_INVERSE) begin
      m0 = cfg_i.d; o0 = q_entry_i.op_x;
      m2 = cfg_i.a; o2 = q_entry_i.op_y;
      m3 = cfg_i.b; o3 = q_entry_i.op_x;
    end else begin
      m0 = cfg_i.a; o0 = q_entry_i.op_x;
      m2 = cfg_i.b; o2 = q_entry_i.op_x;
      m3 = cfg_i.d; o3 = q_entry_i.op_y;
    end
  end

  assign p0_d = PW'(m0) * PW'(o0);
  assign p1_d = PW'(cfg_i.c) * PW'(q_entry_i.op_y);
  assign p2_d = PW'(m2) * PW'(o2);
  assign p3_d = PW'(m3) * PW'(o3);

  // Stage 2 sums; forward adds the translation at full fraction width.
  always_comb begin
    if (s1_inv_q) begin
      nx_d = NV'(p0_q) - NV'(p1_q);
      ny_d = NV'(p2_q) - NV'(p3_q);
    end else begin
      nx_d = NV'(p0_q) + NV'(p1_q) + (NV'(cfg_i.tx) <<< F);
      ny_d = NV'(p2_q) + NV'(p3_q) + (NV'(cfg_i.ty) <<< F);
    end
    det_d = DETW'(pad_q) - DETW'(pbc_q);
  end

  // Pipeline control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      div_done_q  <= 1'b0;
    end else begin
      if (s1_free)  s1_valid_q  <= q_pop_o;
      if (s2_free)  s2_valid_q  <= s1_adv;
      if (out_free) out_valid_q <= out_load;
      if (out_load)     div_done_q <= 1'b0;
      else if (div_fin) div_done_q <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_inv_q <= (q_entry_i.kind == apt_pkg::REQ_INVERSE);
      p0_q     <= p0_d;
      p1_q     <= p1_d;
      p2_q     <= p2_d;
      p3_q     <= p3_d;
      pad_q    <= cfg_i.a * cfg_i.d;
      pbc_q    <= cfg_i.b * cfg_i.c;
    end
    if (s1_adv) begin
      s2_inv_q   <= s1_inv_q;
      nx_q       <= nx_d;
      ny_q       <= ny_d;
      det_neg_q  <= det_d[DETW-1];
      det_zero_q <= (det_d == '0);
      det_abs_q  <= det_d[DETW-1] ? DETW'(-det_d) : DETW'(det_d);
    end
    if (out_load) begin
      x_out_q <= cx.val;
      y_out_q <= cy.val;
      sat_q   <= cx.sat | cy.sat;
      sing_q  <= s2_inv_q && det_zero_q;
    end
  end

  // Magnitudes and signs of the results, then clamping.
  assign nx_abs = nx_q[NV-1] ? NV'(-nx_q) : NV'(nx_q);
  assign ny_abs = ny_q[NV-1] ? NV'(-ny_q) : NV'(ny_q);

  always_comb begin
    if (need_div) begin
      mag_x = quot_x;
      mag_y = quot_y;
      neg_x = nx_q[NV-1] ^ det_neg_q;
      neg_y = ny_q[NV-1] ^ det_neg_q;
    end else begin
      mag_x = NW'(nx_abs >> F);
      mag_y = NW'(ny_abs >> F);
      neg_x = nx_q[NV-1];
      neg_y = ny_q[NV-1];
    end
    cx = apt_pkg::clamp32(mag_x, neg_x);
    cy = apt_pkg::clamp32(mag_y, neg_y);
  end

  // Both dividers run in lock step on the same determinant.
  assign div_fin   = div_fin_x && div_fin_y;
  assign div_start = s2_valid_q && need_div && !div_busy_x && !div_busy_y && !div_done_q;

  apt_div u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({nx_abs, {F{1'b0}}}),
    .den_i  (det_abs_q),
    .busy_o (div_busy_x),
    .done_o (div_fin_x),
    .quot_o (quot_x)
  );

  apt_div u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({ny_abs, {F{1'b0}}}),
    .den_i  (det_abs_q),
    .busy_o (div_busy_y),
    .done_o (div_fin_y),
    .quot_o (quot_y)
  );

  assign out_valid_o = out_valid_q;
  assign x_out_o     = x_out_q;
  assign y_out_o     = y_out_q;
  assign saturated_o = sat_q;
  assign singular_o  = sing_q;

endmodule

// ===== src/affine_point_transform_2d.sv =====
// 2D affine point transform.
// Input channel: in_valid_i / in_stall_o carry one point request (req_type, x, y,
// origin) in signed Q16.16; a request is taken when valid is high and stall low.
// Output channel: out_valid_o / out_stall_i carry one result per request, in
// request order, with saturated and singular flags.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (coef_a,
// coef_b, coef_c, coef_d, shift_x, shift_y); write only while the block is idle.
// A forward request passes through the queue, product stage, sum stage and
// output register, and forward requests stream at one per cycle through the
// multiply and sum stages unless the receiver stalls or the divider holds
// stage 2. An inverse request with a non-zero determinant goes through the
// bit-serial divider: 83 steps; requests behind it wait in the four-entry queue.
// Reset empties the queue and pipeline and loads the identity matrix with zero
// translation. When the receiver stalls, the result holds; the pipeline and
// then the queue fill, after which in_stall_o rises.
module affine_point_transform_2d (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [31:0] x_in_i,
  input  logic signed [31:0] y_in_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] x_out_o,
  output logic signed [31:0] y_out_o,
  output logic               saturated_o,
  output logic               singular_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  apt_pkg::cfg_t   cfg_q;
  apt_pkg::entry_t entry;
  apt_pkg::entry_t head;
  logic            q_full, q_valid, q_pop, push;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a  <= apt_pkg::COEF_ONE;
      cfg_q.b  <= '0;
      cfg_q.c  <= '0;
      cfg_q.d  <= apt_pkg::COEF_ONE;
      cfg_q.tx <= '0;
      cfg_q.ty <= '0;
    end else if (cfg_we_i) begin
      unique case (apt_pkg::cfg_reg_e'(cfg_idx_i))
        apt_pkg::REG_COEF_A:  cfg_q.a  <= cfg_data_i;
        apt_pkg::REG_COEF_B:  cfg_q.b  <= cfg_data_i;
        apt_pkg::REG_COEF_C:  cfg_q.c  <= cfg_data_i;
        apt_pkg::REG_COEF_D:  cfg_q.d  <= cfg_data_i;
        apt_pkg::REG_SHIFT_X: cfg_q.tx <= cfg_data_i;
        apt_pkg::REG_SHIFT_Y: cfg_q.ty <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  apt_front u_front (
    .req_type_i(req_type_i),
    .x_in_i    (x_in_i),
    .y_in_i    (y_in_i),
    .origin_x_i(origin_x_i),
    .origin_y_i(origin_y_i),
    .cfg_i     (cfg_q),
    .entry_o   (entry)
  );

  apt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  apt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_entry_i  (head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .x_out_o    (x_out_o),
    .y_out_o    (y_out_o),
    .saturated_o(saturated_o),
    .singular_o (singular_o)
  );

endmodule

// ===== src/apt_checker.sv =====
module apt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] x_out_o,
  input logic [31:0] y_out_o
);

  // Requests taken but not yet delivered.
  logic [3:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {3'd0, in_acc} - {3'd0, out_acc};
    end
  end

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(x_out_o) && $stable(y_out_o))
    else $error("stalled result changed");

  // No result without a pending request.
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 4'd0)
    else $error("result without request");

  // The queue plus three stages bound what can be in flight.
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'd7)
    else $error("too many requests in flight");

  // Back pressure only once the queue is full.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pend_q >= 4'd4)
    else $error("input stalled with room left");

endmodule

bind affine_point_transform_2d apt_checker u_apt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .x_out_o    (x_out_o),
  .y_out_o    (y_out_o)
);

// ===== bench/affine_point_transform_2d_tb.sv =====
`timescale 1ns / 100ps

module affine_point_transform_2d_tb;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    apt_pkg::req_type_e kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
  } point_req_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               sat;
    logic               sing;
  } point_res_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               req_type_i;
  logic signed [31:0] x_in_i;
  logic signed [31:0] y_in_i;
  logic signed [31:0] origin_x_i;
  logic signed [31:0] origin_y_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] x_out_o;
  logic signed [31:0] y_out_o;
  logic               saturated_o;
  logic               singular_o;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [31:0]        cfg_data_i;

  // Matrix and translation as the block should currently hold them.
  logic signed [31:0] m_a, m_b, m_c, m_d, m_tx, m_ty;

  point_req_t pending_reqs[$];
  point_res_t expected_points[$];
  int         errors;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_token;
  int         hold_seen;
  int         hold_left;
  logic       req_taken;

  affine_point_transform_2d DUT (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Clamps an exact value to the signed 32-bit range.
  function automatic logic signed [31:0] clamp_coord(input wide_t v, inout logic sat);
    if (v > wide_t'(32'sh7FFFFFFF)) begin
      sat = 1'b1;
      return apt_pkg::SAT_MAX;
    end
    if (v < -wide_t'(64'sh80000000)) begin
      sat = 1'b1;
      return apt_pkg::SAT_MIN;
    end
    return v[31:0];
  endfunction

  // Works out the transformed point for one request under the current matrix.
  function automatic point_res_t transform_point(input point_req_t r);
    point_res_t res;
    wide_t a, b, c, d, tx, ty, x, y, ox, oy, u, v, det, nx, ny, rx, ry;
    a = m_a; b = m_b; c = m_c; d = m_d; tx = m_tx; ty = m_ty;
    x = r.x; y = r.y; ox = r.ox; oy = r.oy;
    res.sat  = 1'b0;
    res.sing = 1'b0;
    if (r.kind == apt_pkg::REQ_FORWARD) begin
      rx = (a * x + c * y + tx * 65536) / 65536;
      ry = (b * x + d * y + ty * 65536) / 65536;
    end else begin
      u   = x - (tx - ox);
      v   = y - (ty - oy);
      det = a * d - b * c;
      nx  = d * u - c * v;
      ny  = a * v - b * u;
      if (det == 0) begin
        res.sing = 1'b1;
        rx = nx / 65536;
        ry = ny / 65536;
      end else begin
        // Signed division truncates toward zero, as the block must.
        rx = (nx * 65536) / det;
        ry = (ny * 65536) / det;
      end
    end
    res.x = clamp_coord(rx, res.sat);
    res.y = clamp_coord(ry, res.sat);
    return res;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
      2:       return $signed($urandom_range(0, 32'h7FFFFFF)) - 32'sh4000000;
      default: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
    endcase
  endfunction

  function automatic point_req_t rand_req();
    point_req_t r;
    r.kind = $urandom_range(0, 1) ? apt_pkg::REQ_INVERSE : apt_pkg::REQ_FORWARD;
    r.x  = rand_coord();
    r.y  = rand_coord();
    r.ox = rand_coord();
    r.oy = rand_coord();
    return r;
  endfunction

  task automatic add_req(input apt_pkg::req_type_e k, input logic [31:0] x,
                         input logic [31:0] y, input logic [31:0] ox,
                         input logic [31:0] oy);
    point_req_t r;
    r.kind = k; r.x = x; r.y = y; r.ox = ox; r.oy = oy;
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(input apt_pkg::cfg_reg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic load_matrix(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                             input logic [31:0] d, input logic [31:0] tx,
                             input logic [31:0] ty);
    write_reg(apt_pkg::REG_COEF_A, a);
    write_reg(apt_pkg::REG_COEF_B, b);
    write_reg(apt_pkg::REG_COEF_C, c);
    write_reg(apt_pkg::REG_COEF_D, d);
    write_reg(apt_pkg::REG_SHIFT_X, tx);
    write_reg(apt_pkg::REG_SHIFT_Y, ty);
    m_a = a; m_b = b; m_c = c; m_d = d; m_tx = tx; m_ty = ty;
  endtask

  // Waits until every request has gone in and every result has come out.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_points.size() != 0);
  endtask

  // A request is taken when valid is high and stall low; its result is predicted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        point_req_t r;
        r.kind = apt_pkg::req_type_e'(req_type_i);
        r.x = x_in_i; r.y = y_in_i; r.ox = origin_x_i; r.oy = origin_y_i;
        expected_points.push_back(transform_point(r));
      end
    end
  end

  // Request driver: holds a payload until it is taken, then offers the next.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        point_req_t r;
        r = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= r.kind;
        x_in_i     <= r.x;
        y_in_i     <= r.y;
        origin_x_i <= r.ox;
        origin_y_i <= r.oy;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver stall, with a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen   <= hold_token;
      hold_left   <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_points.size() == 0) begin
        $display("%0t: result expected none actual x=%h y=%h", $time, x_out_o, y_out_o);
        errors++;
      end else begin
        point_res_t e;
        e = expected_points.pop_front();
        if (x_out_o !== e.x) begin
          $display("%0t: x_out expected %h actual %h", $time, e.x, x_out_o);
          errors++;
        end
        if (y_out_o !== e.y) begin
          $display("%0t: y_out expected %h actual %h", $time, e.y, y_out_o);
          errors++;
        end
        if (saturated_o !== e.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, e.sat, saturated_o);
          errors++;
        end
        if (singular_o !== e.sing) begin
          $display("%0t: singular expected %b actual %b", $time, e.sing, singular_o);
          errors++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus.
  initial begin
    errors = 0;
    hold_token = 0;
    hold_seen = 0;
    hold_left = 0;
    send_idle_pct = 15;
    recv_idle_pct = 86;
    in_valid_i = 1'b0;
    req_type_i = apt_pkg::REQ_FORWARD;
    x_in_i = '0; y_in_i = '0; origin_x_i = '0; origin_y_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = apt_pkg::REG_COEF_A;
    cfg_data_i = '0;
    m_a = apt_pkg::COEF_ONE; m_b = '0; m_c = '0; m_d = apt_pkg::COEF_ONE;
    m_tx = '0; m_ty = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Identity after reset: field extremes in both directions.
    add_req(apt_pkg::REQ_FORWARD, 32'h0, 32'h0, 32'h0, 32'h0);
    add_req(apt_pkg::REQ_FORWARD, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF);
    add_req(apt_pkg::REQ_INVERSE, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    add_req(apt_pkg::REQ_INVERSE, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    add_req(apt_pkg::REQ_INVERSE, 32'hFFFFFFFF, 32'h00010000, 32'h0, 32'h0);
    wait_drained();
    repeat (100) @(negedge clk_i);

    // Zero determinant with the most negative coefficients: saturating singular path.
    load_matrix(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h7FFFFFFF, 32'h80000000);
    add_req(apt_pkg::REQ_INVERSE, 32'h0, 32'h0, 32'h0, 32'h0);
    add_req(apt_pkg::REQ_INVERSE, 32'h00000001, 32'hFFFFFFFF, 32'h0, 32'h0);
    add_req(apt_pkg::REQ_INVERSE, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    add_req(apt_pkg::REQ_FORWARD, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h0);
    add_req(apt_pkg::REQ_FORWARD, 32'h00000001, 32'hFFFFFFFF, 32'h0, 32'h0);
    wait_drained();
    repeat (100) @(negedge clk_i);

    // Largest coefficients with a large determinant.
    load_matrix(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    add_req(apt_pkg::REQ_FORWARD, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
    add_req(apt_pkg::REQ_FORWARD, 32'h00000001, 32'h00000001, 32'h0, 32'h0);
    add_req(apt_pkg::REQ_INVERSE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    add_req(apt_pkg::REQ_INVERSE, 32'h00000001, 32'hFFFFFFFF, 32'h0, 32'h0);
    add_req(apt_pkg::REQ_INVERSE, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF);
    // Tiny coefficients so the inverse blows up and saturates.
    wait_drained();
    repeat (100) @(negedge clk_i);
    load_matrix(32'h1, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0);
    add_req(apt_pkg::REQ_INVERSE, 32'h00010000, 32'hFFFF0000, 32'h0, 32'h0);
    add_req(apt_pkg::REQ_INVERSE, 32'h00000001, 32'h00000000, 32'h0, 32'h0);
    add_req(apt_pkg::REQ_FORWARD, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0);
    wait_drained();
    repeat (100) @(negedge clk_i);

    // Random matrices, each with a burst of random points.
    for (int ph = 0; ph < 10; ph++) begin
      logic [31:0] a, b, c, d;
      if (ph < 3) begin
        send_idle_pct = 15; recv_idle_pct = 86;
      end else if (ph < 7) begin
        send_idle_pct = 86; recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (ph % 2 == 0) begin
        a = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        b = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        c = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        d = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      end else begin
        a = $urandom; b = $urandom; c = $urandom; d = $urandom;
      end
      // In one phase a singular matrix.
      if (ph == 5) begin
        c = 32'h0; d = 32'h0;
      end
      load_matrix(a, b, c, d, rand_coord(), rand_coord());
      if (ph == 7) begin
        // Receiver holds off while requests keep coming, so the block backs up.
        hold_token++;
        repeat (25) pending_reqs.push_back(rand_req());
        wait_drained();
      end
      repeat (25) pending_reqs.push_back(rand_req());
      // Sender pauses here until every result is back.
      wait_drained();
      repeat (25) pending_reqs.push_back(rand_req());
      wait_drained();
      repeat (100) @(negedge clk_i);
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== affine_point_transform_2d.f =====
src/apt_pkg.sv
src/apt_front.sv
src/apt_fifo.sv
src/apt_div.sv
src/apt_back.sv
src/affine_point_transform_2d.sv
src/apt_checker.sv
bench/affine_point_transform_2d_tb.sv
